// ===== rtl/civil_date_to_unix_nanoseconds_unit_assert.svh =====
// Assertion macros shared by the checker of the civil date to Unix time unit.
`ifndef CIVIL_DATE_TO_UNIX_NANOSECONDS_UNIT_ASSERT_SVH
`define CIVIL_DATE_TO_UNIX_NANOSECONDS_UNIT_ASSERT_SVH

// Holds at every clock edge outside reset.
`define CDTU_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent, checked from the same edge.
`define CDTU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cdtu_pkg.sv =====
// Types and constants for the civil date to Unix time unit.
package cdtu_pkg;

   typedef logic signed [41:0] secs_type;
   typedef logic [29:0]        frac_type;
   typedef logic signed [63:0] nanos_type;

   // Word handed from the date stages to the nanosecond scaler.
   typedef struct packed {
      logic     valid;
      secs_type secs;
      frac_type frac;
   } secs_word_type;

   // Sub-second enable bit positions.
   localparam int EN_MS = 0;
   localparam int EN_US = 1;
   localparam int EN_NS = 2;

   localparam logic [3:0] MONTH_FEB = 4'd2;

   // Year is biased by 83 eras so the floor division by 400 works on a
   // positive value; quotient via reciprocal, exact below 91199.
   localparam logic [16:0] YEAR_BIAS     = 17'd33200;
   localparam logic [16:0] YEARS_PER_ERA = 17'd400;
   localparam logic [16:0] ERA_RECIP     = 17'd83887;
   localparam int          ERA_SHIFT     = 25;

   // days = 97*q + 365*yo + yoe/4 - yoe/100 + doy - DAY_BIAS
   // (146097*era - 146000*q folded in, era = q - 83, epoch 719468).
   localparam logic [24:0] ERA_DAY_ADJ   = 25'd97;
   localparam logic [24:0] DAYS_PER_YEAR = 25'd365;
   localparam logic [24:0] DAY_BIAS      = 25'd12845519;

   localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
   localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

   localparam logic [29:0]        NS_PER_MS    = 30'd1000000;
   localparam logic [29:0]        NS_PER_US    = 30'd1000;
   localparam logic [29:0]        NS_PER_SEC   = 30'd1000000000;
   localparam logic signed [30:0] NS_PER_SEC_S = 31'sd1000000000;

   localparam nanos_type NS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam nanos_type NS_MIN = 64'sh8000_0000_0000_0000;

   // Days from 1 March to the first of the month; March opens the year.
   function automatic logic [8:0] month_offset(input logic [3:0] month);
      logic [8:0] days;
      unique case (month) inside
         4'd3:        days = 9'd0;
         4'd4:        days = 9'd31;
         4'd5:        days = 9'd61;
         4'd6:        days = 9'd92;
         4'd7:        days = 9'd122;
         4'd8:        days = 9'd153;
         4'd9:        days = 9'd184;
         4'd10:       days = 9'd214;
         4'd11:       days = 9'd245;
         4'd0, 4'd12: days = 9'd275;
         4'd1, 4'd13: days = 9'd306;
         4'd2, 4'd14: days = 9'd337;
         default:     days = 9'd367;
      endcase
      return days;
   endfunction

endpackage

// ===== rtl/cdtu_ns_scale.sv =====
// Seconds to nanoseconds scaler with signed 64-bit saturation, two stages.
module cdtu_ns_scale
   import cdtu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  secs_word_type in_word,
   output logic          out_valid,
   output secs_type      out_secs,
   output nanos_type     out_nanos,
   output logic          out_sat
);

   localparam int SECS_W = $bits(secs_type);
   localparam int LO_W   = 21;
   localparam int PROD_W = 51;
   localparam int SUM_W  = 73;
   localparam int NS_W   = $bits(nanos_type);

   // stage 4: split multiply
   logic signed [SECS_W-LO_W-1:0] s4_hi_sec;
   logic [LO_W-1:0]               s4_lo_sec;
   logic signed [PROD_W-1:0]      s4_hi_in, s4_hi_ff;
   logic [PROD_W-1:0]             s4_lo_in, s4_lo_ff;
   secs_type                      s4_secs_ff;
   frac_type                      s4_frac_ff;
   logic                          s4_valid_ff;

   // stage 5: recombine and clamp
   logic signed [SUM_W-1:0] s5_total;
   logic                    s5_fits;
   nanos_type               s5_nanos_in, s5_nanos_ff;
   logic                    s5_sat_in, s5_sat_ff;
   secs_type                s5_secs_ff;
   logic                    s5_valid_ff;

   assign s4_hi_sec = in_word.secs[SECS_W-1:LO_W];
   assign s4_lo_sec = in_word.secs[LO_W-1:0];
   assign s4_hi_in  = s4_hi_sec * NS_PER_SEC_S;
   assign s4_lo_in  = s4_lo_sec * NS_PER_SEC;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= in_word.valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_hi_ff    <= s4_hi_in;
      s4_lo_ff    <= s4_lo_in;
      s4_secs_ff  <= in_word.secs;
      s4_frac_ff  <= in_word.frac;
      s5_nanos_ff <= s5_nanos_in;
      s5_sat_ff   <= s5_sat_in;
      s5_secs_ff  <= s4_secs_ff;
   end

   // exact value, then check it sits in signed 64 bits
   assign s5_total = (SUM_W'(s4_hi_ff) <<< LO_W) + SUM_W'(s4_lo_ff) + SUM_W'(s4_frac_ff);
   assign s5_fits  = (&s5_total[SUM_W-1:NS_W-1]) | ~(|s5_total[SUM_W-1:NS_W-1]);

   always_comb begin
      s5_sat_in = ~s5_fits;
      if (s5_fits) begin
         s5_nanos_in = s5_total[NS_W-1:0];
      end else if (s5_total[SUM_W-1]) begin
         s5_nanos_in = NS_MIN;
      end else begin
         s5_nanos_in = NS_MAX;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_secs  = s5_secs_ff;
   assign out_nanos = s5_nanos_ff;
   assign out_sat   = s5_sat_ff;

endmodule

// ===== rtl/civil_date_to_unix_nanoseconds_unit.sv =====
// Civil date and time to Unix seconds and nanoseconds, top level.
//
// Takes one proleptic Gregorian date and time with a zone offset in minutes
// and gives UTC Unix seconds plus Unix nanoseconds. A word is taken at every
// clock edge where start is high; busy is held low, so a word may be offered
// every cycle and the unit sustains one word per clock. The result is driven
// on the rsp_ ports from the last of five register stages, marked by
// rsp_valid for exactly one cycle; there is no backpressure, so the receiver
// must take it then. The stages are: era split by reciprocal multiply, day
// count, seconds (days times 86400), a split seconds-times-1e9 multiply,
// and the 73-bit recombine with clamp. Fields are not range checked:
// out-of-range hours, minutes, days and sub-second parts roll forward
// linearly, month zero is December of the year before and months thirteen
// to fifteen run on into the next year. unix_seconds is always exact; when
// the nanosecond value leaves signed 64 bits it is held at the nearest bound
// and rsp_range_overflow is raised. Nothing is stored between words and
// there is no start-up pass after reset.
module civil_date_to_unix_nanoseconds_unit
   import cdtu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_year,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day,
   input  logic [4:0]         req_hour,
   input  logic [5:0]         req_minute,
   input  logic [5:0]         req_second,
   input  logic [9:0]         req_millisecond,
   input  logic [9:0]         req_microsecond,
   input  logic [9:0]         req_nanosecond,
   input  logic signed [11:0] req_zone_offset_minutes,
   input  logic [2:0]         req_subsecond_enables,
   output logic               rsp_valid,
   output logic signed [41:0] rsp_unix_seconds,
   output logic signed [63:0] rsp_unix_nanoseconds,
   output logic               rsp_range_overflow
);

   // Stage 1: year adjust, era quotient product, day of year, time of day
   // and sub-second sum.
   logic                accept;
   logic signed [16:0]  s1_yadj;
   logic [16:0]         s1_yo_in, s1_yo_ff;
   logic [33:0]         s1_qprod;
   logic [7:0]          s1_q_in, s1_q_ff;
   logic signed [9:0]   s1_doy_in, s1_doy_ff;
   logic signed [18:0]  s1_tod_in, s1_tod_ff;
   logic [29:0]         s1_ms_ns, s1_us_ns, s1_ns_ns;
   frac_type            s1_frac_in, s1_frac_ff;
   logic                s1_valid_ff;

   // Stage 2: year of era, century correction, day count.
   logic [16:0]         s2_q400;
   logic [8:0]          s2_yoe;
   logic [1:0]          s2_cent;
   logic signed [24:0]  s2_days_in, s2_days_ff;
   logic signed [18:0]  s2_tod_ff;
   frac_type            s2_frac_ff;
   logic                s2_valid_ff;

   // Stage 3: seconds.
   secs_type            s3_secs_in, s3_secs_ff;
   frac_type            s3_frac_ff;
   logic                s3_valid_ff;
   secs_word_type       s3_word;

   // No backpressure anywhere, so a word is always welcome.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // ---- stage 1 ----
   // January and February (and month zero) count as the tail of the year before.
   assign s1_yadj  = 17'(req_year) - ((req_month <= MONTH_FEB) ? 17'sd1 : 17'sd0);
   assign s1_yo_in = 17'(s1_yadj) + YEAR_BIAS;
   assign s1_qprod = s1_yo_in * ERA_RECIP;
   assign s1_q_in  = s1_qprod[ERA_SHIFT +: 8];

   // Signed: day zero of March gives minus one.
   assign s1_doy_in = 10'(month_offset(req_month)) + 10'(req_day) - 10'd1;

   assign s1_tod_in = 19'(req_hour) * 19'(SEC_PER_HOUR)
                    + 19'(req_minute) * 19'(SEC_PER_MIN)
                    + 19'(req_second)
                    - 19'(req_zone_offset_minutes) * 19'(SEC_PER_MIN);

   assign s1_ms_ns   = req_subsecond_enables[EN_MS] ? 30'(req_millisecond) * NS_PER_MS : '0;
   assign s1_us_ns   = req_subsecond_enables[EN_US] ? 30'(req_microsecond) * NS_PER_US : '0;
   assign s1_ns_ns   = req_subsecond_enables[EN_NS] ? 30'(req_nanosecond) : '0;
   assign s1_frac_in = s1_ms_ns + s1_us_ns + s1_ns_ns;

   // ---- stage 2 ----
   assign s2_q400 = 17'(s1_q_ff) * YEARS_PER_ERA;
   assign s2_yoe  = 9'(s1_yo_ff - s2_q400);

   // yoe / 100 for yoe below 400
   always_comb begin
      if (s2_yoe >= 9'd300) begin
         s2_cent = 2'd3;
      end else if (s2_yoe >= 9'd200) begin
         s2_cent = 2'd2;
      end else if (s2_yoe >= 9'd100) begin
         s2_cent = 2'd1;
      end else begin
         s2_cent = 2'd0;
      end
   end

   // era*146097 + yoe*365 folded into q and yo terms, see package
   assign s2_days_in = 25'(s1_q_ff) * ERA_DAY_ADJ
                     + 25'(s1_yo_ff) * DAYS_PER_YEAR
                     + 25'(s2_yoe[8:2])
                     - 25'(s2_cent)
                     + 25'(s1_doy_ff)
                     - DAY_BIAS;

   // ---- stage 3 ----
   assign s3_secs_in = 42'(s2_days_ff) * 42'(SEC_PER_DAY) + 42'(s2_tod_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_yo_ff   <= s1_yo_in;
      s1_q_ff    <= s1_q_in;
      s1_doy_ff  <= s1_doy_in;
      s1_tod_ff  <= s1_tod_in;
      s1_frac_ff <= s1_frac_in;
      s2_days_ff <= s2_days_in;
      s2_tod_ff  <= s1_tod_ff;
      s2_frac_ff <= s1_frac_ff;
      s3_secs_ff <= s3_secs_in;
      s3_frac_ff <= s2_frac_ff;
   end

   assign s3_word = '{valid: s3_valid_ff, secs: s3_secs_ff, frac: s3_frac_ff};

   // ---- stages 4 and 5: scale to nanoseconds, saturate ----
   cdtu_ns_scale u_ns_scale (
      .clock     (clock),
      .reset     (reset),
      .in_word   (s3_word),
      .out_valid (rsp_valid),
      .out_secs  (rsp_unix_seconds),
      .out_nanos (rsp_unix_nanoseconds),
      .out_sat   (rsp_range_overflow)
   );

endmodule

// ===== rtl/cdtu_checker.sv =====
// Port-level checker for the civil date to Unix time unit, bound to the top level.
`include "civil_date_to_unix_nanoseconds_unit_assert.svh"

module cdtu_checker
   import cdtu_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [15:0] req_year,
   input logic [3:0]         req_month,
   input logic [4:0]         req_day,
   input logic [4:0]         req_hour,
   input logic [5:0]         req_minute,
   input logic [5:0]         req_second,
   input logic [9:0]         req_millisecond,
   input logic [9:0]         req_microsecond,
   input logic [9:0]         req_nanosecond,
   input logic signed [11:0] req_zone_offset_minutes,
   input logic [2:0]         req_subsecond_enables,
   input logic               rsp_valid,
   input logic signed [41:0] rsp_unix_seconds,
   input logic signed [63:0] rsp_unix_nanoseconds,
   input logic               rsp_range_overflow
);

   // pipeline never pushes back
   `CDTU_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy, "busy raised")

   // every accepted word is followed by a result
   `CDTU_ASSERT_IMPLY(a_result_follows, clock, reset, start && !busy, ##5 rsp_valid, "result lost")

   // no result without an earlier accepted word
   `CDTU_ASSERT_IMPLY(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy, 5), "spurious result")

   // saturated value is the bound on the side of the seconds' sign
   `CDTU_ASSERT_IMPLY(a_sat_bound, clock, reset, rsp_valid && rsp_range_overflow, (rsp_unix_nanoseconds == NS_MAX && !rsp_unix_seconds[41]) || (rsp_unix_nanoseconds == NS_MIN && rsp_unix_seconds[41]), "bad saturation")

endmodule

bind civil_date_to_unix_nanoseconds_unit cdtu_checker u_cdtu_checker (.*);

// ===== verif/cdtu_check_pkg.sv =====
// Date word type, Unix time predictor and result scoreboard for the date unit bench.
`timescale 1ns / 100ps

package cdtu_check_pkg;
   import cdtu_pkg::*;

   typedef struct {
      logic signed [15:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic [9:0]         millisecond;
      logic [9:0]         microsecond;
      logic [9:0]         nanosecond;
      logic signed [11:0] zone_offset_minutes;
      logic [2:0]         subsecond_enables;
   } civil_stamp_type;

   typedef struct {
      secs_type  unix_seconds;
      nanos_type unix_nanoseconds;
      logic      range_overflow;
   } epoch_type;

   localparam int MAX_REPORTS = 10;

   // Day count from the March-based year, then seconds, then clamped nanoseconds.
   function automatic epoch_type predict_epoch(civil_stamp_type s);
      longint yr, mon, dy, era, yoe, doy, doe, days, secs, frac;
      longint hh, mi, ss, zone, ms, us, ns;
      logic signed [127:0] wide;
      epoch_type e;
      yr   = longint'(s.year);
      mon  = longint'(s.month);
      dy   = longint'(s.day);
      hh   = longint'(s.hour);
      mi   = longint'(s.minute);
      ss   = longint'(s.second);
      ms   = longint'(s.millisecond);
      us   = longint'(s.microsecond);
      ns   = longint'(s.nanosecond);
      zone = longint'(s.zone_offset_minutes);
      if (mon <= 2) begin
         yr = yr - 1;
      end
      // floor division by 400
      era  = (yr >= 0 ? yr : yr - 399) / 400;
      yoe  = yr - era * 400;
      doy  = (153 * (mon + (mon > 2 ? -3 : 9)) + 2) / 5 + dy - 1;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468;
      secs = days * 86400 + hh * 3600 + mi * 60 + ss - zone * 60;
      frac = 0;
      if (s.subsecond_enables[EN_MS]) begin
         frac = frac + ms * 1000000;
      end
      if (s.subsecond_enables[EN_US]) begin
         frac = frac + us * 1000;
      end
      if (s.subsecond_enables[EN_NS]) begin
         frac = frac + ns;
      end
      // exact product in 128 bits, clamp to the signed 64-bit bounds
      wide = 128'(secs);
      wide = wide * 1000000000 + frac;
      e.unix_seconds = secs[41:0];
      if (wide > NS_MAX) begin
         e.unix_nanoseconds = NS_MAX;
         e.range_overflow   = 1'b1;
      end else if (wide < NS_MIN) begin
         e.unix_nanoseconds = NS_MIN;
         e.range_overflow   = 1'b1;
      end else begin
         e.unix_nanoseconds = wide[63:0];
         e.range_overflow   = 1'b0;
      end
      return e;
   endfunction

   class epoch_scoreboard;
      epoch_type   pending_epochs[$];
      int unsigned failures = 0;

      function void log_failure(string what);
         failures++;
         if (failures <= MAX_REPORTS) begin
            $display("mismatch %0d: %s", failures, what);
         end
      endfunction

      function void note_stamp(civil_stamp_type s);
         pending_epochs.push_back(predict_epoch(s));
      endfunction

      function void check_result(secs_type secs, nanos_type nanos, logic overflow);
         epoch_type want;
         if (pending_epochs.size() == 0) begin
            log_failure($sformatf("unexpected word secs=%0d ns=%0d ovf=%b",
                                  secs, nanos, overflow));
            return;
         end
         want = pending_epochs.pop_front();
         if (secs !== want.unix_seconds || nanos !== want.unix_nanoseconds ||
             overflow !== want.range_overflow) begin
            log_failure($sformatf("expected secs=%0d ns=%0d ovf=%b, got secs=%0d ns=%0d ovf=%b",
                                  want.unix_seconds, want.unix_nanoseconds,
                                  want.range_overflow, secs, nanos, overflow));
         end
      endfunction
   endclass

endpackage

// ===== verif/testbench.sv =====
// Top-level bench for the civil date to Unix time unit: stimulus, monitor and verdict.
`timescale 1ns / 100ps

module testbench
   import cdtu_pkg::*;
   import cdtu_check_pkg::*;
;

   localparam int RANDOM_WORDS = 650;
   // last stretch of the random part runs flat out, no gaps
   localparam int QUIET_TAIL   = 150;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_year = '0;
   logic [3:0]         req_month = '0;
   logic [4:0]         req_day = '0;
   logic [4:0]         req_hour = '0;
   logic [5:0]         req_minute = '0;
   logic [5:0]         req_second = '0;
   logic [9:0]         req_millisecond = '0;
   logic [9:0]         req_microsecond = '0;
   logic [9:0]         req_nanosecond = '0;
   logic signed [11:0] req_zone_offset_minutes = '0;
   logic [2:0]         req_subsecond_enables = '0;
   logic               rsp_valid;
   logic signed [41:0] rsp_unix_seconds;
   logic signed [63:0] rsp_unix_nanoseconds;
   logic               rsp_range_overflow;

   epoch_scoreboard epoch_sb = new();

   civil_date_to_unix_nanoseconds_unit u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_year                (req_year),
      .req_month               (req_month),
      .req_day                 (req_day),
      .req_hour                (req_hour),
      .req_minute              (req_minute),
      .req_second              (req_second),
      .req_millisecond         (req_millisecond),
      .req_microsecond         (req_microsecond),
      .req_nanosecond          (req_nanosecond),
      .req_zone_offset_minutes (req_zone_offset_minutes),
      .req_subsecond_enables   (req_subsecond_enables),
      .rsp_valid               (rsp_valid),
      .rsp_unix_seconds        (rsp_unix_seconds),
      .rsp_unix_nanoseconds    (rsp_unix_nanoseconds),
      .rsp_range_overflow      (rsp_range_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run (~700 words with the longest gaps).
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Results cannot be held off, so every strobed cycle is checked at the edge
   // that closes it; the values read here are the ones before that edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         epoch_sb.check_result(rsp_unix_seconds, rsp_unix_nanoseconds, rsp_range_overflow);
      end
   end

   function automatic civil_stamp_type make_stamp(int yr, int mo, int dy, int hh, int mi,
                                                  int ss, int ms, int us, int ns, int zone,
                                                  int en);
      civil_stamp_type s;
      s.year                = 16'(yr);
      s.month               = 4'(mo);
      s.day                 = 5'(dy);
      s.hour                = 5'(hh);
      s.minute              = 6'(mi);
      s.second              = 6'(ss);
      s.millisecond         = 10'(ms);
      s.microsecond         = 10'(us);
      s.nanosecond          = 10'(ns);
      s.zone_offset_minutes = 12'(zone);
      s.subsecond_enables   = 3'(en);
      return s;
   endfunction

   // Present a word and hold it until an edge sees start high and busy low.
   // start stays high on return so back-to-back words need no re-raise.
   task automatic send_stamp(input civil_stamp_type s);
      start                   <= 1'b1;
      req_year                <= s.year;
      req_month               <= s.month;
      req_day                 <= s.day;
      req_hour                <= s.hour;
      req_minute              <= s.minute;
      req_second              <= s.second;
      req_millisecond         <= s.millisecond;
      req_microsecond         <= s.microsecond;
      req_nanosecond          <= s.nanosecond;
      req_zone_offset_minutes <= s.zone_offset_minutes;
      req_subsecond_enables   <= s.subsecond_enables;
      do @(posedge clock); while (busy !== 1'b0);
      epoch_sb.note_stamp(s);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      civil_stamp_type directed[$];
      civil_stamp_type s;
      int pick;
      bit gappy;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed words ---
      // epoch itself, and the last nanosecond before it
      directed.push_back(make_stamp(1970, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_stamp(1969, 12, 31, 23, 59, 59, 999, 999, 999, 0, 7));
      // exact top of the signed 64-bit range, then one nanosecond past it
      directed.push_back(make_stamp(2262, 4, 11, 23, 47, 16, 854, 775, 807, 0, 7));
      directed.push_back(make_stamp(2262, 4, 11, 23, 47, 16, 854, 775, 808, 0, 7));
      // exact bottom, one nanosecond under it, and the same second with no sub-second part
      directed.push_back(make_stamp(1677, 9, 21, 0, 12, 43, 145, 224, 192, 0, 7));
      directed.push_back(make_stamp(1677, 9, 21, 0, 12, 43, 145, 224, 191, 0, 7));
      directed.push_back(make_stamp(1677, 9, 21, 0, 12, 43, 0, 0, 0, 0, 0));
      // year extremes with the widest zone offsets
      directed.push_back(make_stamp(-32768, 1, 1, 0, 0, 0, 0, 0, 0, 2047, 0));
      directed.push_back(make_stamp(32767, 12, 31, 23, 59, 60, 1023, 1023, 1023, -2048, 7));
      directed.push_back(make_stamp(32767, 15, 31, 31, 63, 63, 1023, 1023, 1023, -2048, 7));
      // month zero, and months past December
      directed.push_back(make_stamp(2000, 0, 15, 12, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_stamp(2000, 13, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_stamp(2000, 14, 29, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_stamp(2000, 15, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      // day zero before 1 March in a leap year, and Feb 31 rolling on
      directed.push_back(make_stamp(2000, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_stamp(1900, 2, 31, 0, 0, 0, 0, 0, 0, 0, 0));
      // overflowing hour/minute/second fields and a leap second
      directed.push_back(make_stamp(2024, 6, 30, 31, 63, 63, 0, 0, 0, 0, 0));
      directed.push_back(make_stamp(2016, 12, 31, 23, 59, 60, 0, 0, 0, 0, 0));
      // each sub-second enable on its own
      directed.push_back(make_stamp(2001, 9, 9, 1, 46, 40, 123, 456, 789, 0, 1));
      directed.push_back(make_stamp(2001, 9, 9, 1, 46, 40, 123, 456, 789, 0, 2));
      directed.push_back(make_stamp(2001, 9, 9, 1, 46, 40, 123, 456, 789, 0, 4));
      // nominal zone limits
      directed.push_back(make_stamp(1970, 1, 1, 0, 0, 0, 0, 0, 0, -1440, 3));
      directed.push_back(make_stamp(1970, 1, 1, 0, 0, 0, 0, 0, 0, 1440, 5));
      // era boundaries around year zero
      directed.push_back(make_stamp(0, 2, 29, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_stamp(-400, 3, 1, 0, 0, 0, 0, 0, 0, 0, 6));
      directed.push_back(make_stamp(-401, 2, 28, 0, 0, 0, 0, 0, 0, 0, 0));

      foreach (directed[i]) begin
         send_stamp(directed[i]);
      end

      // --- random words ---
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            // raw bit patterns: every field over its full width
            s.year                = 16'($urandom);
            s.month               = 4'($urandom);
            s.day                 = 5'($urandom);
            s.hour                = 5'($urandom);
            s.minute              = 6'($urandom);
            s.second              = 6'($urandom);
            s.millisecond         = 10'($urandom);
            s.microsecond         = 10'($urandom);
            s.nanosecond          = 10'($urandom);
            s.zone_offset_minutes = 12'($urandom);
            s.subsecond_enables   = 3'($urandom);
         end else begin
            s = make_stamp($urandom_range(1600, 2400), $urandom_range(1, 12),
                           $urandom_range(1, 31), $urandom_range(0, 23),
                           $urandom_range(0, 59), $urandom_range(0, 60),
                           $urandom_range(0, 999), $urandom_range(0, 999),
                           $urandom_range(0, 999), int'($urandom_range(0, 2880)) - 1440,
                           $urandom_range(0, 7));
            // a share lands in the years where the nanosecond clamp bites
            if (pick < 40) begin
               s.year = ($urandom_range(0, 1) != 0) ? 16'sd2262 : 16'sd1677;
            end
         end

         // gappy and flat-out stretches alternate; the tail stays flat out
         gappy = ((i / 60) % 2 == 0) && (i < RANDOM_WORDS - QUIET_TAIL);
         if (gappy && $urandom_range(0, 9) < 4) begin
            hold_off($urandom_range(1, 11));
         end
         send_stamp(s);
      end
      start <= 1'b0;

      // drain, then run on past the five-stage pipeline to catch strays
      while (epoch_sb.pending_epochs.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (epoch_sb.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
